>>> rtl/ght_pkg.sv
`default_nettype none

package ght_pkg;

	localparam int DEF_SLOT_COUNT = 64;
	localparam int DEF_OWNER_BITS = 16;

	localparam int OWNER_FIELD_W = 16;
	localparam int GEN_W         = 24;
	localparam int GRP_W         = 8;
	localparam int GRP_OFF_W     = 3;

	localparam logic [7:0]       TAG_VALUE = 8'h44;
	localparam logic [GEN_W-1:0] GEN_MAX   = 24'hFF_FFFF;
	localparam logic [GEN_W-1:0] GEN_FIRST = 24'h00_0001;

	localparam logic [1:0] OP_CREATE  = 2'd0;
	localparam logic [1:0] OP_LOOKUP  = 2'd1;
	localparam logic [1:0] OP_DESTROY = 2'd2;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_INVALID = 2'd1;
	localparam logic [1:0] ST_FULL    = 2'd2;

	typedef struct packed {
		logic [1:0]               opcode;
		logic [63:0]              handle_in;
		logic [OWNER_FIELD_W-1:0] owner_id;
	} ght_req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [63:0] handle_out;
		logic [5:0]  slot_index;
	} ght_rsp_t;

	typedef struct packed {
		logic capture;
		logic find;
		logic exec;
	} ght_cmd_t;

	typedef enum logic [2:0] {
		FSM_IDLE = 3'b001,
		FSM_FIND = 3'b010,
		FSM_EXEC = 3'b100
	} ght_state_t;

endpackage

`default_nettype wire

>>> rtl/generational_handle_table.sv
`default_nettype none

// generational handle table: a fixed table of slots hands out 64-bit handles
// (tag 0x44 in bits 63..56, slot generation in 55..32, slot index plus one in
// 31..0). create takes the lowest free slot, lookup checks a handle against
// tag, index, generation, occupancy and owner, destroy checks the same way,
// frees the slot and advances its generation (0xffffff wraps to 1).
// a transaction is taken when start is high and busy is low. its result
// is registered on rsp as the execute state ends, with done high for
// exactly one cycle; the receiver cannot stall, so it must take rsp in that
// cycle. busy is low again in the done cycle, so a new transaction may start
// then; none is taken while busy is high.
// the steps are: capture plus first level of the free-slot search,
// second level of the search plus the registered table read, then the
// table write and result register. the table is usable straight after reset,
// with no clearing pass.

module generational_handle_table
	import ght_pkg::*;
#(
	parameter int SLOT_COUNT = DEF_SLOT_COUNT,
	parameter int OWNER_BITS = DEF_OWNER_BITS
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     start,
	output logic          busy,
	input  wire ght_req_t req,
	output logic          done,
	output ght_rsp_t      rsp
);

	// command bundle from the sequencer to the datapath
	ght_cmd_t cmd;

	// sequencer: idle, search/read, execute
	ght_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.done   (done)
	);

	// slot table, free-slot search and handle checks
	ght_dpath #(
		.SLOT_COUNT (SLOT_COUNT),
		.OWNER_BITS (OWNER_BITS)
	) u_dpath (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.req    (req),
		.rsp    (rsp)
	);

endmodule

`default_nettype wire

>>> rtl/ght_ctrl.sv
`default_nettype none

module ght_ctrl
	import ght_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	output logic      busy,
	output ght_cmd_t  cmd,
	output logic      done
);

	ght_state_t state_q;
	ght_state_t state_d;
	logic       done_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			FSM_IDLE: begin
				if (start) begin
					state_d = FSM_FIND;
				end
			end
			FSM_FIND: state_d = FSM_EXEC;
			FSM_EXEC: state_d = FSM_IDLE;
			default:  state_d = FSM_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FSM_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == FSM_EXEC);
		end
	end

	assign busy        = (state_q != FSM_IDLE);
	assign cmd.capture = (state_q == FSM_IDLE) && start;
	assign cmd.find    = (state_q == FSM_FIND);
	assign cmd.exec    = (state_q == FSM_EXEC);
	assign done        = done_q;

endmodule

`default_nettype wire

>>> rtl/ght_dpath.sv
`default_nettype none

module ght_dpath
	import ght_pkg::*;
#(
	parameter int SLOT_COUNT = DEF_SLOT_COUNT,
	parameter int OWNER_BITS = DEF_OWNER_BITS
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire ght_cmd_t cmd,
	input  wire ght_req_t req,
	output ght_rsp_t      rsp
);

	localparam int IDX_W  = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam int OWN_W  = (OWNER_BITS < OWNER_FIELD_W) ? OWNER_BITS : OWNER_FIELD_W;
	localparam int NGRP   = (SLOT_COUNT + GRP_W - 1) / GRP_W;
	localparam int PAD    = NGRP * GRP_W;
	localparam int GSEL_W = (NGRP > 1) ? $clog2(NGRP) : 1;
	localparam int CAND_W = GSEL_W + GRP_OFF_W;

	// table state
	logic [SLOT_COUNT-1:0] busy_q;
	logic [SLOT_COUNT-1:0] genv_q;
	logic [GEN_W-1:0]      gen_mem [SLOT_COUNT];
	logic [OWN_W-1:0]      own_mem [SLOT_COUNT];

	// captured request
	logic [1:0]       op_q;
	logic [63:0]      hdl_q;
	logic [OWN_W-1:0] own_q;

	// first level of the free-slot search
	logic [NGRP-1:0]      grp_free_q;
	logic [GRP_OFF_W-1:0] grp_off_q [NGRP];
	logic [NGRP-1:0]      grp_free_d;
	logic [GRP_OFF_W-1:0] grp_off_d [NGRP];
	logic [PAD-1:0]       free_pad;

	// second level and address select
	logic              grp_hit;
	logic [GSEL_W-1:0] grp_sel;
	logic [CAND_W-1:0] cand;
	logic [31:0]       hidx;
	logic [IDX_W-1:0]  addr;
	logic              hdr_ok;

	// registered table read
	logic [IDX_W-1:0] slot_q;
	logic             full_q;
	logic             hdr_ok_q;
	logic [GEN_W-1:0] gen_rd_q;
	logic [OWN_W-1:0] own_rd_q;
	logic             busy_rd_q;
	logic             genv_rd_q;

	logic [GEN_W-1:0] gen_cur;
	logic [GEN_W-1:0] gen_next;
	logic             chk_ok;
	logic [IDX_W+5:0] slot_ext;
	ght_rsp_t         rsp_d;
	ght_rsp_t         rsp_q;

	always_comb begin
		free_pad = PAD'(~busy_q);
		for (int g = 0; g < NGRP; g++) begin
			grp_free_d[g] = 1'b0;
			grp_off_d[g]  = '0;
			for (int b = GRP_W - 1; b >= 0; b--) begin
				if (free_pad[g*GRP_W + b]) begin
					grp_free_d[g] = 1'b1;
					grp_off_d[g]  = GRP_OFF_W'(b);
				end
			end
		end
	end

	always_comb begin
		grp_hit = 1'b0;
		grp_sel = '0;
		for (int g = NGRP - 1; g >= 0; g--) begin
			if (grp_free_q[g]) begin
				grp_hit = 1'b1;
				grp_sel = GSEL_W'(g);
			end
		end
		cand = {grp_sel, grp_off_q[grp_sel]};
		hidx = hdl_q[31:0] - 32'd1;
		if (op_q == OP_CREATE) begin
			addr = cand[IDX_W-1:0];
		end else begin
			addr = hidx[IDX_W-1:0];
		end
		hdr_ok = (hdl_q[63:56] == TAG_VALUE) && (hdl_q[31:0] != 32'd0) &&
			(hdl_q[55:32] != '0) && (hdl_q[31:0] <= 32'(SLOT_COUNT));
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q  <= req.opcode;
			hdl_q <= req.handle_in;
			own_q <= req.owner_id[OWN_W-1:0];
			grp_free_q <= grp_free_d;
			grp_off_q  <= grp_off_d;
		end
		if (cmd.find) begin
			slot_q    <= addr;
			full_q    <= !grp_hit;
			hdr_ok_q  <= hdr_ok;
			gen_rd_q  <= gen_mem[addr];
			own_rd_q  <= own_mem[addr];
			busy_rd_q <= busy_q[addr];
			genv_rd_q <= genv_q[addr];
		end
	end

	always_comb begin
		gen_cur  = genv_rd_q ? gen_rd_q : GEN_FIRST;
		gen_next = (gen_cur == GEN_MAX) ? GEN_FIRST : gen_cur + GEN_FIRST;
		chk_ok   = hdr_ok_q && busy_rd_q && (gen_cur == hdl_q[55:32]) &&
			(own_rd_q == own_q);
		slot_ext = {6'd0, slot_q};
	end

	// memories: written on the execute cycle only
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			if ((op_q == OP_CREATE) && !full_q) begin
				own_mem[slot_q] <= own_q;
			end
			if ((op_q == OP_DESTROY) && chk_ok) begin
				gen_mem[slot_q] <= gen_next;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= '0;
			genv_q <= '0;
		end else if (cmd.exec) begin
			if ((op_q == OP_CREATE) && !full_q) begin
				busy_q[slot_q] <= 1'b1;
			end
			if ((op_q == OP_DESTROY) && chk_ok) begin
				busy_q[slot_q] <= 1'b0;
				genv_q[slot_q] <= 1'b1;
			end
		end
	end

	always_comb begin
		rsp_d.status     = ST_INVALID;
		rsp_d.handle_out = '0;
		rsp_d.slot_index = '0;
		case (op_q) inside
			OP_CREATE: begin
				if (full_q) begin
					rsp_d.status = ST_FULL;
				end else begin
					rsp_d.status     = ST_OK;
					rsp_d.handle_out = {TAG_VALUE, gen_cur, 32'(slot_q) + 32'd1};
					rsp_d.slot_index = slot_ext[5:0];
				end
			end
			OP_LOOKUP, OP_DESTROY: begin
				if (chk_ok) begin
					rsp_d.status     = ST_OK;
					rsp_d.slot_index = slot_ext[5:0];
				end
			end
			default: begin
				rsp_d.status = ST_INVALID;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp = rsp_q;

endmodule

`default_nettype wire
